/* hw/rtl/bts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types, codes and constants of the bilinear texture sampler.
// ----------------------------------------------------------------------------
package bts_pkg;

    localparam int TEXELS_DEFAULT = 4096;
    localparam int QUEUE_DEPTH    = 4;
    localparam int CH_W           = 8;
    localparam int COORD_W        = 16;
    localparam int SIZE_W         = 4;
    localparam int TEXEL_W        = 3 * CH_W;
    localparam int TADDR_W        = 12;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = SIZE_W;
    localparam int TAPS           = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BILINEAR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_LOG2_RESET = 4'd6;

    // item kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [COORD_W-1:0]  u_coord;
        logic [COORD_W-1:0]  v_coord;
        logic [TADDR_W-1:0]  texel_address;
        logic [CH_W-1:0]     red_in;
        logic [CH_W-1:0]     green_in;
        logic [CH_W-1:0]     blue_in;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
    } t_out_item;

    typedef struct packed {
        logic              bilinear_enable;
        logic [SIZE_W-1:0] width_log2;
        logic [SIZE_W-1:0] height_log2;
    } t_cfg;

    // classified command handed from front to back
    typedef struct packed {
        logic                kind;
        logic [COORD_W-1:0]  fx;
        logic [COORD_W-1:0]  fy;
        logic [TEXEL_W-1:0]  wdata;
    } t_cmd;

endpackage

/* hw/rtl/bts_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_in_if
// Valid/ready channel carrying texel writes and sample requests.
// ----------------------------------------------------------------------------
interface bts_in_if import bts_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/bts_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_out_if
// Valid/ready channel carrying sampled colors.
// ----------------------------------------------------------------------------
interface bts_out_if import bts_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/bilinear_texture_sampler_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_unit
// RGB texture sampler with nearest or bilinear filtering and repeat wrap.
// ----------------------------------------------------------------------------
// One item is taken per clock, writes and samples alike, while the output is
// not stalled. A write item stores a texel and gives no result; a sample item
// gives one color, registered after it leaves the internal queue in the texel
// fetch, then horizontal blend, then vertical blend into the output register.
// The rate is set by the texel store: it is held as four identical copies,
// each with one read port, so the four neighbor texels of a bilinear sample
// come out in the same cycle, and every write goes to all four copies. The
// output stalls the whole back pipeline, while the front keeps filling a short
// queue. Nearest mode runs through the same path with zero weights. The
// configuration registers are written through a plain write port; the user
// must write them only while the unit is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_unit import bts_pkg::*; #(
    parameter int TEXELS = TEXELS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bts_in_if.sink                i_in,
    bts_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int AW = $clog2(TEXELS);
    localparam int QW = $bits(t_cmd) + TAPS * AW;

    t_cfg                      r_cfg;

    // front to queue
    logic                      w_push;
    t_cmd                      w_cmd_in;
    logic [TAPS-1:0][AW-1:0]   w_addr_in;
    logic                      w_q_ready;

    // queue to back
    logic                      w_q_valid;
    logic                      w_pop;
    logic [QW-1:0]             w_q_data;
    t_cmd                      w_cmd_out;
    logic [TAPS-1:0][AW-1:0]   w_addr_out;

    // configuration registers, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bilinear_enable <= 1'b0;
            r_cfg.width_log2      <= SIZE_LOG2_RESET;
            r_cfg.height_log2     <= SIZE_LOG2_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BILINEAR: r_cfg.bilinear_enable <= i_cfg_data[0];
                CFG_WIDTH:    r_cfg.width_log2      <= i_cfg_data;
                CFG_HEIGHT:   r_cfg.height_log2     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // address and weight generation
    bts_front #(
        .TEXELS (TEXELS)
    ) u_front (
        .i_in      (i_in),
        .i_cfg     (r_cfg),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_cmd     (w_cmd_in),
        .o_addr    (w_addr_in)
    );

    // decoupling queue
    bts_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_cmd_in, w_addr_in}),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    assign w_cmd_out  = w_q_data[QW-1 -: $bits(t_cmd)];
    assign w_addr_out = w_q_data[TAPS*AW-1:0];

    // texel store and blend pipeline
    bts_back #(
        .TEXELS (TEXELS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_pop     (w_pop),
        .i_cmd     (w_cmd_out),
        .i_addr    (w_addr_out),
        .o_out     (o_out)
    );
endmodule

/* hw/rtl/bts_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hw/rtl/bts_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_front
// Classifies items: four wrapped texel addresses and blend weights per sample.
// ----------------------------------------------------------------------------
module bts_front import bts_pkg::*; #(
    parameter int TEXELS = TEXELS_DEFAULT
) (
    bts_in_if.sink                              i_in,
    input  t_cfg                                i_cfg,
    input  logic                                i_q_ready,
    output logic                                o_push,
    output t_cmd                                o_cmd,
    output logic [TAPS-1:0][$clog2(TEXELS)-1:0] o_addr
);
    localparam int AW = $clog2(TEXELS);
    localparam int SW = COORD_W + 15;   // scaled coordinate, shift up to 15
    localparam int IW = 15;             // texel column / row index

    logic [SW-1:0] w_s;
    logic [SW-1:0] w_t;
    logic [SW-1:0] w_ds;
    logic [SW-1:0] w_dt;
    logic [IW-1:0] w_col0;
    logic [IW-1:0] w_row0;
    logic [IW-1:0] w_col1;
    logic [IW-1:0] w_row1;
    logic [IW-1:0] w_wmask;
    logic [IW-1:0] w_hmask;
    logic [COORD_W-1:0] w_fx;
    logic [COORD_W-1:0] w_fy;
    logic [SW-1:0] w_half;

    function automatic logic [AW-1:0] f_addr(input logic [IW-1:0] col,
                                             input logic [IW-1:0] row,
                                             input logic [SIZE_W-1:0] wl);
        logic [SW-1:0] sum;
        sum = (SW'(row) << wl) + SW'(col);
        return AW'(sum);
    endfunction

    assign w_half  = SW'(17'h08000);
    assign w_s     = SW'(i_in.data.u_coord) << i_cfg.width_log2;
    assign w_t     = SW'(i_in.data.v_coord) << i_cfg.height_log2;
    assign w_ds    = w_s - w_half;
    assign w_dt    = w_t - w_half;
    assign w_wmask = (IW'(1) << i_cfg.width_log2) - IW'(1);
    assign w_hmask = (IW'(1) << i_cfg.height_log2) - IW'(1);

    always_comb begin
        if (!i_cfg.bilinear_enable) begin
            w_col0 = w_s[SW-1:COORD_W];
            w_row0 = w_t[SW-1:COORD_W];
            w_fx   = '0;
            w_fy   = '0;
        end else begin
            // floor at the low border: base -1, weight shifted up by half a texel
            if (w_s >= w_half) begin
                w_col0 = w_ds[SW-1:COORD_W];
                w_fx   = w_ds[COORD_W-1:0];
            end else begin
                w_col0 = '1;
                w_fx   = w_s[COORD_W-1:0] + COORD_W'(16'h8000);
            end
            if (w_t >= w_half) begin
                w_row0 = w_dt[SW-1:COORD_W];
                w_fy   = w_dt[COORD_W-1:0];
            end else begin
                w_row0 = '1;
                w_fy   = w_t[COORD_W-1:0] + COORD_W'(16'h8000);
            end
        end
    end

    assign w_col1 = w_col0 + IW'(1);
    assign w_row1 = w_row0 + IW'(1);

    always_comb begin
        o_cmd.kind  = i_in.data.kind;
        o_cmd.fx    = w_fx;
        o_cmd.fy    = w_fy;
        o_cmd.wdata = {i_in.data.red_in, i_in.data.green_in, i_in.data.blue_in};
        if (i_in.data.kind == KIND_WRITE) begin
            o_addr    = '0;
            o_addr[0] = AW'(32'(i_in.data.texel_address));
        end else begin
            o_addr[0] = f_addr(w_col0 & w_wmask, w_row0 & w_hmask, i_cfg.width_log2);
            o_addr[1] = f_addr(w_col1 & w_wmask, w_row0 & w_hmask, i_cfg.width_log2);
            o_addr[2] = f_addr(w_col0 & w_wmask, w_row1 & w_hmask, i_cfg.width_log2);
            o_addr[3] = f_addr(w_col1 & w_wmask, w_row1 & w_hmask, i_cfg.width_log2);
        end
    end

    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid & i_q_ready;
endmodule

/* hw/rtl/bts_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_queue
// Small register FIFO between front and back.
// ----------------------------------------------------------------------------
module bts_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;

    always_comb begin
        n_wp  = i_push ? r_wp + PW'(1) : r_wp;
        n_rp  = i_pop  ? r_rp + PW'(1) : r_rp;
        n_cnt = r_cnt + CW'(i_push) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_cnt == CW'(DEPTH)))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_cnt == '0))
        else $error("queue pop while empty");
endmodule

/* hw/rtl/bts_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_back
// Texel store copies, fetch stage and two-stage bilinear blend pipeline.
// ----------------------------------------------------------------------------
module bts_back import bts_pkg::*; #(
    parameter int TEXELS = TEXELS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    output logic                                o_pop,
    input  t_cmd                                i_cmd,
    input  logic [TAPS-1:0][$clog2(TEXELS)-1:0] i_addr,
    bts_out_if.source                           o_out
);
    localparam int WW = COORD_W + 1;        // 65536 - weight
    localparam int HW = CH_W + COORD_W;     // horizontal blend, Q8.16
    localparam int MW = HW + COORD_W + 1;   // vertical blend with headroom

    logic                  w_adv;
    logic                  w_we;
    logic                  w_re;
    logic [TEXEL_W-1:0]    w_tex [TAPS];

    logic                  r_v1;
    logic [COORD_W-1:0]    r_fx1;
    logic [COORD_W-1:0]    r_fy1;
    logic                  r_v2;
    logic [COORD_W-1:0]    r_fy2;
    logic [HW-1:0]         r_top [3];
    logic [HW-1:0]         r_bot [3];
    logic                  r_v3;
    logic [TEXEL_W-1:0]    r_rgb;

    logic [HW-1:0]         n_top [3];
    logic [HW-1:0]         n_bot [3];
    logic [TEXEL_W-1:0]    n_rgb;

    // whole pipeline moves together, held by the output register
    assign w_adv = !r_v3 || o_out.ready;
    assign o_pop = w_adv && i_q_valid;
    assign w_we  = o_pop && (i_cmd.kind == KIND_WRITE);
    assign w_re  = o_pop && (i_cmd.kind == KIND_SAMPLE);

    for (genvar g = 0; g < TAPS; g++) begin : g_copy
        bts_ram #(
            .WIDTH (TEXEL_W),
            .DEPTH (TEXELS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (i_addr[0]),
            .i_wdata (i_cmd.wdata),
            .i_re    (w_re),
            .i_raddr (i_addr[g]),
            .o_rdata (w_tex[g])
        );
    end

    always_comb begin
        logic [WW-1:0] ifx;
        ifx = WW'(17'h10000) - WW'(r_fx1);
        for (int k = 0; k < 3; k++) begin
            n_top[k] = HW'(w_tex[0][TEXEL_W-1-CH_W*k -: CH_W]) * HW'(ifx)
                     + HW'(w_tex[1][TEXEL_W-1-CH_W*k -: CH_W]) * HW'(r_fx1);
            n_bot[k] = HW'(w_tex[2][TEXEL_W-1-CH_W*k -: CH_W]) * HW'(ifx)
                     + HW'(w_tex[3][TEXEL_W-1-CH_W*k -: CH_W]) * HW'(r_fx1);
        end
    end

    always_comb begin
        logic [WW-1:0] ify;
        logic [MW-1:0] mix;
        ify   = WW'(17'h10000) - WW'(r_fy2);
        n_rgb = '0;
        for (int k = 0; k < 3; k++) begin
            mix = MW'(r_top[k]) * MW'(ify) + MW'(r_bot[k]) * MW'(r_fy2)
                + MW'(33'h080000000);
            // round half up, clamp to full scale
            if (mix[MW-1:2*COORD_W+CH_W] != '0) begin
                n_rgb[TEXEL_W-1-CH_W*k -: CH_W] = '1;
            end else begin
                n_rgb[TEXEL_W-1-CH_W*k -: CH_W] = mix[2*COORD_W +: CH_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= w_re;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fx1 <= i_cmd.fx;
            r_fy1 <= i_cmd.fy;
            r_fy2 <= r_fy1;
            r_top <= n_top;
            r_bot <= n_bot;
            r_rgb <= n_rgb;
        end
    end

    assign o_out.valid = r_v3;
    assign o_out.data  = r_rgb;

    a_rw_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re))
        else $error("texel store written and read by one item");

    a_sample_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_re |=> r_v1)
        else $error("popped sample lost at fetch stage");
endmodule

/* bench/bilinear_texture_sampler_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_unit_tb
// Self-checking bench for the texture sampler: texel writes and nearest or
// bilinear samples are driven with random gaps and back pressure, and every
// sampled color is compared with a color computed in the bench itself.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_unit_tb;
    import bts_pkg::*;

    // scoreboard: keeps its own texel store and settings, and a queue of
    // colors that the sampler still owes
    class color_scoreboard;
        logic [TEXEL_W-1:0] texels [TEXELS_DEFAULT];
        bit                 bilinear;
        int unsigned        wlog;
        int unsigned        hlog;
        t_out_item          owed_colors [$];
        int                 errors;
        int                 checked;

        function new();
            bilinear = 0;
            wlog = SIZE_LOG2_RESET;
            hlog = SIZE_LOG2_RESET;
            errors = 0;
            checked = 0;
            foreach (texels[i]) texels[i] = '0;
        endfunction

        function longint unsigned addr_of(longint unsigned col, longint unsigned row);
            longint unsigned wmask;
            longint unsigned hmask;
            wmask = (64'd1 << wlog) - 1;
            hmask = (64'd1 << hlog) - 1;
            return (((row & hmask) << wlog) + (col & wmask)) % TEXELS_DEFAULT;
        endfunction

        function logic [TEXEL_W-1:0] fetch(longint unsigned col, longint unsigned row);
            return texels[addr_of(col, row)];
        endfunction

        // floor of the half-texel centered coordinate, and its weight
        function void split(longint unsigned sc, output longint unsigned b,
                            output longint unsigned f);
            if (sc >= 64'h8000) begin
                b = (sc - 64'h8000) >> 16;
                f = (sc - 64'h8000) & 64'hFFFF;
            end else begin
                b = 64'hFFFF_FFFF_FFFF_FFFF;
                f = sc + 64'h8000;
            end
        endfunction

        // store entries that a sample reads, one entry four times when nearest
        function void tap_addrs(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v,
                                output int unsigned a [4]);
            longint unsigned s, t, s0, fx, t0, fy;
            s = longint'(u) << wlog;
            t = longint'(v) << hlog;
            if (!bilinear) begin
                foreach (a[i]) a[i] = 32'(addr_of(s >> 16, t >> 16));
            end else begin
                split(s, s0, fx);
                split(t, t0, fy);
                a[0] = 32'(addr_of(s0, t0));
                a[1] = 32'(addr_of(s0 + 1, t0));
                a[2] = 32'(addr_of(s0, t0 + 1));
                a[3] = 32'(addr_of(s0 + 1, t0 + 1));
            end
        endfunction

        // note one accepted input item
        function void note_item(t_in_item it);
            longint unsigned s, t, s0, fx, t0, fy, top, bot, mix, val;
            logic [TEXEL_W-1:0] tx [4];
            logic [TEXEL_W-1:0] px;
            t_out_item c;
            if (it.kind == KIND_WRITE) begin
                texels[it.texel_address] = {it.red_in, it.green_in, it.blue_in};
                return;
            end
            s = longint'(it.u_coord) << wlog;
            t = longint'(it.v_coord) << hlog;
            if (!bilinear) begin
                px = fetch(s >> 16, t >> 16);
                c = px;
            end else begin
                split(s, s0, fx);
                split(t, t0, fy);
                tx[0] = fetch(s0, t0);
                tx[1] = fetch(s0 + 1, t0);
                tx[2] = fetch(s0, t0 + 1);
                tx[3] = fetch(s0 + 1, t0 + 1);
                for (int k = 0; k < 3; k++) begin
                    top = longint'(tx[0][16-8*k +: 8]) * (65536 - fx)
                        + longint'(tx[1][16-8*k +: 8]) * fx;
                    bot = longint'(tx[2][16-8*k +: 8]) * (65536 - fx)
                        + longint'(tx[3][16-8*k +: 8]) * fx;
                    mix = top * (65536 - fy) + bot * fy;
                    val = (mix + 64'h8000_0000) >> 32;
                    if (val > 255) val = 255;
                    c[16-8*k +: 8] = val[7:0];
                end
            end
            owed_colors.push_back(c);
        endfunction

        // compare one accepted color with the oldest one owed
        function void check_color(t_out_item got);
            t_out_item exp_c;
            if (owed_colors.size() == 0) begin
                $error("color with none owed: %h", got);
                errors++;
                return;
            end
            exp_c = owed_colors.pop_front();
            checked++;
            if (got.red_out !== exp_c.red_out) begin
                $error("red_out expected %0d got %0d", exp_c.red_out, got.red_out);
                errors++;
            end
            if (got.green_out !== exp_c.green_out) begin
                $error("green_out expected %0d got %0d", exp_c.green_out, got.green_out);
                errors++;
            end
            if (got.blue_out !== exp_c.blue_out) begin
                $error("blue_out expected %0d got %0d", exp_c.blue_out, got.blue_out);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    bts_in_if  in_ch ();
    bts_out_if out_ch ();

    color_scoreboard sb = new();
    int unsigned cycles = 0;
    bit long_hold = 0;     // receiver stays off while this is set
    int unsigned samples_sent = 0;

    localparam int unsigned CYCLE_LIMIT = 400000;

    // store entries already written by the driver, so the bench model reads no unwritten entry
    bit known [TEXELS_DEFAULT];

    always #5 i_clk = ~i_clk;

    bilinear_texture_sampler_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // monitor: sample both handshakes at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) sb.note_item(in_ch.data);
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_color(out_ch.data);
    end

    // receiver: random stalls, with one long hold-off on request
    initial begin
        int unsigned gap;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (long_hold) begin
                out_ch.ready <= 1'b0;
                @(posedge i_clk);
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
                if ($urandom_range(0, 9) < 3) gap = 0;
                if (gap > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
                while (!out_ch.valid) @(posedge i_clk);
            end
        end
    end

    // send one item with a random gap ahead of it
    task automatic send(t_in_item it, bit no_gap);
        int unsigned gap;
        gap = no_gap ? 0 : $urandom_range(0, 8);
        if (it.kind == KIND_WRITE) known[it.texel_address] = 1'b1;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (it.kind == KIND_SAMPLE) samples_sent++;
    endtask

    task automatic finish_items();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed_colors.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_BILINEAR) sb.bilinear = val[0];
        if (idx == CFG_WIDTH) sb.wlog = 32'(val);
        if (idx == CFG_HEIGHT) sb.hlog = 32'(val);
    endtask

    function automatic t_in_item texel_item(int unsigned addr);
        t_in_item it;
        it = '0;
        it.kind = KIND_WRITE;
        it.u_coord = COORD_W'($urandom());
        it.v_coord = COORD_W'($urandom());
        it.texel_address = TADDR_W'(addr);
        it.red_in = CH_W'($urandom());
        it.green_in = CH_W'($urandom());
        it.blue_in = CH_W'($urandom());
        return it;
    endfunction

    function automatic t_in_item sample_item(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
        t_in_item it;
        it = '0;
        it.kind = KIND_SAMPLE;
        it.u_coord = u;
        it.v_coord = v;
        it.texel_address = TADDR_W'($urandom());
        it.red_in = CH_W'($urandom());
        it.green_in = CH_W'($urandom());
        it.blue_in = CH_W'($urandom());
        return it;
    endfunction

    // write any entry the sample reads that is still unwritten, then sample
    task automatic send_sample(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v, bit no_gap);
        int unsigned taps [4];
        sb.tap_addrs(u, v, taps);
        foreach (taps[i]) begin
            if (!known[taps[i]]) send(texel_item(taps[i]), 1'b1);
        end
        send(sample_item(u, v), no_gap);
    endtask

    // drain and reprogram
    task automatic setup(bit bil, int unsigned wl, int unsigned hl);
        finish_items();
        write_reg(CFG_BILINEAR, CFG_DATA_W'(bil));
        write_reg(CFG_WIDTH, CFG_DATA_W'(wl));
        write_reg(CFG_HEIGHT, CFG_DATA_W'(hl));
    endtask

    initial begin
        t_in_item it;
        int unsigned mode;
        int unsigned wl, hl;
        logic [COORD_W-1:0] corner_vals [6] = '{16'h0000, 16'hFFFF, 16'h8000,
                                                16'h7FFF, 16'h0001, 16'h4000};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset sizes 64x64: corners
        for (int k = 0; k < 6; k++) send_sample(corner_vals[k], corner_vals[5-k], 1'b0);
        // extreme channel values and the low border wrap in bilinear mode
        setup(1'b1, 1, 1);
        for (int a = 0; a < 4; a++) send(texel_item(a), 1'b0);
        send(texel_item(0) | {TEXEL_W{1'b1}}, 1'b0);
        for (int k = 0; k < 6; k++) send_sample(corner_vals[k], corner_vals[k], 1'b0);
        // sizes above twelve and a one-texel texture
        setup(1'b0, 15, 15);
        send_sample(16'hFFFF, 16'hFFFF, 1'b0);
        setup(1'b1, 0, 0);
        send_sample(16'h0000, 16'hFFFF, 1'b0);
        send_sample(16'h8000, 16'h8000, 1'b0);
        setup(1'b1, 12, 0);
        send_sample(16'hFFFF, 16'h0000, 1'b0);
        setup(1'b1, 0, 12);
        send_sample(16'h0000, 16'hFFFF, 1'b0);

        // back pressure: receiver holds off while samples keep coming
        setup(1'b1, 3, 2);
        long_hold = 1;
        fork
            begin
                repeat (200) @(posedge i_clk);
                long_hold = 0;
            end
            for (int n = 0; n < 40; n++)
                send_sample(COORD_W'($urandom()), COORD_W'($urandom()), 1'b1);
        join

        // random phases, mostly small textures
        for (int ph = 0; ph < 10; ph++) begin
            mode = $urandom_range(0, 1);
            wl = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
            hl = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
            if (wl + hl > 12 && ph % 3 != 0) hl = 0;
            setup(mode[0], wl, hl);
            for (int n = 0; n < 130; n++) begin
                if ($urandom_range(0, 4) == 0) begin
                    it = texel_item($urandom_range(0, TEXELS_DEFAULT - 1));
                    send(it, $urandom_range(0, 2) == 0);
                end else begin
                    send_sample(COORD_W'($urandom()), COORD_W'($urandom()),
                                $urandom_range(0, 2) == 0);
                end
            end
        end
        finish_items();
        $display("covered %0d of %0d sample colors over nearest and bilinear modes,",
                 sb.checked, samples_sent);
        $display("texture sizes from 1 to 2^15 per side, with stalls on both sides");
        if (sb.errors == 0 && sb.owed_colors.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

/* bilinear_texture_sampler_unit.f */
hw/rtl/bts_pkg.sv
hw/rtl/bts_in_if.sv
hw/rtl/bts_out_if.sv
hw/rtl/bts_ram.sv
hw/rtl/bts_front.sv
hw/rtl/bts_queue.sv
hw/rtl/bts_back.sv
hw/rtl/bilinear_texture_sampler_unit.sv
bench/bilinear_texture_sampler_unit_tb.sv
